// ===== rtl/ioapic_pkg.sv =====
// Shared types, constants and helpers of the I/O APIC redirection controller.
// Used by ioapic_tbl and io_apic_redirection_controller_unit; depends on nothing.
package ioapic_pkg;

	localparam int PIN_COUNT_DEF    = 24;
	localparam int VERSION_CODE_DEF = 32;

	localparam int ENT_W     = 64;
	localparam int B_DMODE   = 11;
	localparam int B_DSTAT   = 12;
	localparam int B_POL     = 13;
	localparam int B_RIRR    = 14;
	localparam int B_LEVEL   = 15;
	localparam int B_MASK    = 16;

	localparam logic [ENT_W-1:0] ENT_RESET = 64'h0000_0000_0001_0000;
	localparam logic [31:0] RO_BITS    = 32'h0000_5000;
	localparam logic [31:0] MSI_PREFIX = 32'hFEE0_0000;
	localparam logic [31:0] ALL_ONES   = 32'hFFFF_FFFF;
	localparam logic [7:0]  SEL_ID     = 8'h00;
	localparam logic [7:0]  SEL_VER    = 8'h01;
	localparam logic [7:0]  SEL_ARB    = 8'h02;
	localparam logic [7:0]  SEL_TABLE  = 8'h10;

	localparam logic [1:0] MODE_READ  = 2'd0;
	localparam logic [1:0] MODE_WRITE = 2'd1;
	localparam logic [1:0] MODE_PIN   = 2'd2;

	localparam logic [1:0] WIN_SEL  = 2'd0;
	localparam logic [1:0] WIN_DATA = 2'd1;
	localparam logic [1:0] WIN_EOI  = 2'd2;

	typedef enum logic [1:0] {
		S_IDLE,
		S_READ,
		S_EOI,
		S_OUT
	} state_t;

	typedef enum logic [1:0] {
		OP_RD,
		OP_WR,
		OP_PIN
	} op_t;

	typedef struct packed {
		logic rd_en;
		logic wr_en;
	} tbl_ctl_t;

	function automatic logic [31:0] msi_addr(input logic [ENT_W-1:0] e);
		msi_addr = MSI_PREFIX | {12'd0, e[63:56], 12'd0} | {29'd0, e[B_DMODE], 2'd0};
	endfunction

	function automatic logic [15:0] msi_data(input logic [ENT_W-1:0] e);
		msi_data = {e[B_LEVEL], ~e[B_POL], 3'd0, e[10:0]};
	endfunction

endpackage

// ===== rtl/ioapic_tbl.sv =====
// Redirection table memory: one write and one registered read port per cycle.
// Per-entry valid bits give the reset value until an entry is written; uses ioapic_pkg.
module ioapic_tbl import ioapic_pkg::*; #(
	parameter int PIN_COUNT = PIN_COUNT_DEF,
	parameter int IW        = 5
) (
	input  logic             clk,
	input  logic             arst_n,
	input  tbl_ctl_t         ctl,
	input  logic [IW-1:0]    rd_addr,
	input  logic [IW-1:0]    wr_addr,
	input  logic [ENT_W-1:0] wr_data,
	output logic [ENT_W-1:0] rd_data
);

	logic [ENT_W-1:0]     mem [PIN_COUNT];
	logic [PIN_COUNT-1:0] valid_q;
	logic [ENT_W-1:0]     rd_q;
	logic                 rd_vld_q;

	always_ff @(posedge clk) begin
		if (ctl.wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (ctl.rd_en) begin
			rd_q <= mem[rd_addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q  <= '0;
			rd_vld_q <= 1'b0;
		end else begin
			if (ctl.wr_en) begin
				valid_q[wr_addr] <= 1'b1;
			end
			if (ctl.rd_en) begin
				rd_vld_q <= valid_q[rd_addr];
			end
		end
	end

	assign rd_data = rd_vld_q ? rd_q : ENT_RESET;

endmodule

// ===== rtl/io_apic_redirection_controller_unit.sv =====
// I/O APIC redirection controller: select/window/EOI registers, pin events, MSI out.
// Register and select accesses go to the result register and then the output register;
// table reads, writes and pin events pass through a table read first, and an EOI write
// scans every entry, one table read per cycle through the single read port. One item at
// a time; a finished result waits in the output register while the next item is taken.
// Reset (arst_n low, asynchronous): ID and select zero, all entries masked, no pending.
module io_apic_redirection_controller_unit import ioapic_pkg::*; #(
	parameter int PIN_COUNT    = PIN_COUNT_DEF,
	parameter int VERSION_CODE = VERSION_CODE_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [47:0] s_tdata,   // mode[1:0], window[3:2], write_data[35:4], pin[40:36]
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [87:0] m_tdata    // read_data[31:0], msi_valid[32], msi_address[64:33],
	                               // msi_data[80:65], legacy_valid[81], legacy_line[85:82]
);

	localparam int IW = (PIN_COUNT > 1) ? $clog2(PIN_COUNT) : 1;
	localparam logic [IW-1:0] LAST = IW'(PIN_COUNT - 1);
	localparam logic [31:0] VERSION_WORD =
		32'(VERSION_CODE & 255) | (32'(PIN_COUNT - 1) << 16);

	state_t state_q, state_d;
	op_t    op_q;

	logic [7:0]           sel_q;
	logic [31:0]          id_q;
	logic [PIN_COUNT-1:0] pend_q;
	logic [31:0]          wd_q;
	logic                 hi_q;
	logic [IW-1:0]        idx_q;
	logic [IW-1:0]        ctr_q;

	logic [31:0] r_rd_q, r_ma_q;
	logic [15:0] r_md_q;
	logic        r_mv_q, r_lv_q;
	logic [3:0]  r_ll_q;

	logic        m_valid_q;
	logic [31:0] m_rd_q, m_ma_q;
	logic [15:0] m_md_q;
	logic        m_mv_q, m_lv_q;
	logic [3:0]  m_ll_q;

	logic [1:0]  in_mode, in_win;
	logic [31:0] in_wd;
	logic [4:0]  in_pin;
	logic        acc, slot_free;
	logic [7:0]  sel_off, sel_n;
	logic        sel_ent, pin_ok;
	logic        go_rd, go_eoi;
	logic [IW-1:0] acc_idx;
	logic [31:0] reg_word;

	tbl_ctl_t         ctl;
	logic [IW-1:0]    rd_addr;
	logic [ENT_W-1:0] wr_data, rd_data;

	logic [ENT_W-1:0] e_w, e_new;
	logic             ev_fire, ev_msi, ev_wr, ev_pset, ev_pclr, ev_leg;
	logic [ENT_W-1:0] ev_ent;

	assign in_mode = s_tdata[1:0];
	assign in_win  = s_tdata[3:2];
	assign in_wd   = s_tdata[35:4];
	assign in_pin  = s_tdata[40:36];

	assign acc       = s_tvalid && s_tready;
	assign slot_free = !m_valid_q || m_tready;

	assign sel_off = sel_q - SEL_TABLE;
	assign sel_n   = {1'b0, sel_off[7:1]};
	assign sel_ent = (sel_q >= SEL_TABLE) && (32'(sel_n) < 32'(PIN_COUNT));
	assign pin_ok  = 32'(in_pin) < 32'(PIN_COUNT);

	assign go_rd = ((in_mode == MODE_READ || in_mode == MODE_WRITE)
			&& in_win == WIN_DATA && sel_ent)
		|| (in_mode == MODE_PIN && pin_ok);
	assign go_eoi  = in_mode == MODE_WRITE && in_win == WIN_EOI;
	assign acc_idx = (in_mode == MODE_PIN) ? IW'({3'd0, in_pin}) : IW'(sel_n);

	always_comb begin
		if (sel_q == SEL_ID || sel_q == SEL_ARB) begin
			reg_word = id_q;
		end else if (sel_q == SEL_VER) begin
			reg_word = VERSION_WORD;
		end else begin
			reg_word = ALL_ONES;
		end
	end

	ioapic_tbl #(.PIN_COUNT(PIN_COUNT), .IW(IW)) u_tbl (
		.clk     (clk),
		.arst_n  (arst_n),
		.ctl     (ctl),
		.rd_addr (rd_addr),
		.wr_addr ((state_q == S_EOI) ? ctr_q : idx_q),
		.wr_data (wr_data),
		.rd_data (rd_data)
	);

	always_comb begin
		e_w = hi_q ? {wd_q, rd_data[31:0]}
			: {rd_data[63:32], (wd_q & ~RO_BITS) | (rd_data[31:0] & RO_BITS)};
		ev_ent  = (op_q == OP_WR) ? e_w : rd_data;
		ev_fire = 1'b0;
		ev_msi  = 1'b0;
		ev_pset = 1'b0;
		ev_pclr = 1'b0;
		ev_leg  = 1'b0;
		if (op_q == OP_WR) begin
			ev_pclr = !e_w[B_MASK];
			ev_fire = !e_w[B_MASK] && pend_q[idx_q];
			ev_leg  = ev_fire && (32'(idx_q) < 16);
			ev_msi  = ev_fire && !e_w[B_RIRR];
		end else if (op_q == OP_PIN) begin
			ev_pset = rd_data[B_MASK] && rd_data[B_LEVEL];
			ev_msi  = !rd_data[B_MASK] && !rd_data[B_RIRR];
		end
		e_new = ev_ent;
		if (ev_msi && ev_ent[B_LEVEL]) begin
			e_new[B_RIRR] = 1'b1;
		end
		ev_wr = (op_q == OP_WR) || (ev_msi && ev_ent[B_LEVEL]);
	end

	always_comb begin
		unique case (state_q)
			S_IDLE:  state_d = acc ? (go_rd ? S_READ : (go_eoi ? S_EOI : S_OUT)) : S_IDLE;
			S_READ:  state_d = S_OUT;
			S_EOI:   state_d = (ctr_q == LAST) ? S_OUT : S_EOI;
			S_OUT:   state_d = slot_free ? S_IDLE : S_OUT;
			default: state_d = S_IDLE;
		endcase
	end

	always_comb begin
		s_tready  = 1'b0;
		ctl       = '0;
		rd_addr   = '0;
		wr_data   = e_new;
		unique case (state_q)
			S_IDLE: begin
				s_tready  = 1'b1;
				ctl.rd_en = acc && (go_rd || go_eoi);
				rd_addr   = go_eoi ? '0 : acc_idx;
			end
			S_READ: begin
				ctl.wr_en = ev_wr;
			end
			S_EOI: begin
				ctl.rd_en = ctr_q != LAST;
				rd_addr   = ctr_q + 1'b1;
				ctl.wr_en = rd_data[7:0] == wd_q[7:0] && rd_data[B_RIRR];
				wr_data   = rd_data & ~(ENT_W'(1) << B_RIRR);
			end
			S_OUT: begin
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			sel_q     <= '0;
			id_q      <= '0;
			pend_q    <= '0;
			m_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (acc && in_mode == MODE_WRITE && in_win == WIN_SEL) begin
				sel_q <= in_wd[7:0];
			end
			if (acc && in_mode == MODE_WRITE && in_win == WIN_DATA && sel_q == SEL_ID) begin
				id_q <= in_wd;
			end
			if (state_q == S_READ && ev_pclr) begin
				pend_q[idx_q] <= 1'b0;
			end
			if (state_q == S_READ && ev_pset) begin
				pend_q[idx_q] <= 1'b1;
			end
			if (state_q == S_OUT && slot_free) begin
				m_valid_q <= 1'b1;
			end else if (m_tready) begin
				m_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (acc) begin
			op_q   <= (in_mode == MODE_PIN) ? OP_PIN : ((in_mode == MODE_WRITE) ? OP_WR : OP_RD);
			wd_q   <= in_wd;
			hi_q   <= sel_off[0];
			idx_q  <= acc_idx;
			ctr_q  <= '0;
			r_rd_q <= '0;
			r_mv_q <= 1'b0;
			r_ma_q <= '0;
			r_md_q <= '0;
			r_lv_q <= in_mode == MODE_PIN && in_pin < 5'd16;
			r_ll_q <= (in_mode == MODE_PIN && in_pin < 5'd16) ? in_pin[3:0] : 4'd0;
			if (in_mode == MODE_READ) begin
				case (in_win)
					WIN_SEL:  r_rd_q <= {24'd0, sel_q};
					WIN_DATA: r_rd_q <= reg_word;
					WIN_EOI:  r_rd_q <= '0;
					default:  r_rd_q <= ALL_ONES;
				endcase
			end
		end
		if (state_q == S_READ) begin
			if (op_q == OP_RD) begin
				r_rd_q <= hi_q ? rd_data[63:32] : rd_data[31:0];
			end
			if (ev_msi) begin
				r_mv_q <= 1'b1;
				r_ma_q <= msi_addr(ev_ent);
				r_md_q <= msi_data(ev_ent);
			end
			if (ev_leg) begin
				r_lv_q <= 1'b1;
				r_ll_q <= 4'(idx_q);
			end
		end
		if (state_q == S_EOI) begin
			ctr_q <= ctr_q + 1'b1;
		end
		if (state_q == S_OUT && slot_free) begin
			m_rd_q <= r_rd_q;
			m_mv_q <= r_mv_q;
			m_ma_q <= r_ma_q;
			m_md_q <= r_md_q;
			m_lv_q <= r_lv_q;
			m_ll_q <= r_ll_q;
		end
	end

	assign m_tvalid = m_valid_q;
	assign m_tdata  = {2'd0, m_ll_q, m_lv_q, m_md_q, m_ma_q, m_mv_q, m_rd_q};

	a_no_rw_clash: assert property (@(posedge clk) disable iff (!arst_n)
		(ctl.rd_en && ctl.wr_en) |-> (rd_addr != ((state_q == S_EOI) ? ctr_q : idx_q)))
		else $error("table read and write hit the same entry");

	a_out_holds: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_OUT && m_valid_q && !m_tready) |=> state_q == S_OUT)
		else $error("result left while output slot occupied");

	a_eoi_bound: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_EOI |-> 32'(ctr_q) < 32'(PIN_COUNT))
		else $error("EOI scan beyond table");

	a_msi_prefix: assert property (@(posedge clk) disable iff (!arst_n)
		(m_valid_q && m_mv_q) |-> m_ma_q[31:20] == MSI_PREFIX[31:20])
		else $error("MSI address without prefix");

endmodule
